[sv/swn_pkg.sv]
// Shared types and constants for the skinning weight normaliser.
// Holds the field widths, buffer sizes, the queue entry type and the state encodings.
// No dependencies.
`default_nettype none

package swn_pkg;

    // Buffer and selection sizes
    localparam int MAX_INFLUENCES = 8;
    localparam int KEEP_COUNT     = 4;

    // Field widths
    localparam int ID_W     = 8;
    localparam int WEIGHT_W = 20;
    localparam int BIND_W   = 24;
    localparam int NORM_W   = 17;
    localparam int FRAC_W   = 16;

    localparam int IDX_W = $clog2(MAX_INFLUENCES);
    localparam int CNT_W = $clog2(MAX_INFLUENCES + 1);
    localparam int SUM_W = WEIGHT_W + $clog2(KEEP_COUNT);

    // Queue between the front and the back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(NORM_W);

    // Port widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (ID_W + NORM_W + 2 * BIND_W);
    localparam int OUT_USER_W = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_PAD_W  = CFG_DATA_W - WEIGHT_W;

    // Register index codes (byte address bit 2 upwards)
    localparam logic [0:0] REG_MIN_WEIGHT = 1'b0;

    typedef struct packed {
        logic        [ID_W-1:0]     id;
        logic        [WEIGHT_W-1:0] weight;
        logic signed [BIND_W-1:0]   bind_x;
        logic signed [BIND_W-1:0]   bind_y;
        logic        [SUM_W-1:0]    sum;
        logic                       empty;
        logic                       ovf;
        logic                       last;
    } t_q_entry;

    typedef enum logic [3:0] {
        F_LOAD = 4'b0001,
        F_RANK = 4'b0010,
        F_SUM  = 4'b0100,
        F_PUSH = 4'b1000
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_HOLD = 3'b100
    } t_back_state;

endpackage

`default_nettype wire

[sv/skin_weight_top4_normalize.sv]
// With the back idle and the result stream ready, each result of a vertex is popped from the
// queue, divided in 17 divider steps and loaded into the output register; when nothing
// survives, the single empty marker skips the divider.
// Throughput: influences are taken one per cycle while a vertex loads; after the final one the
// input is held off while the front ranks, sums and pushes the kept set, longer while the queue
// is full. Reset is synchronous and active low; it empties the buffer, the queue and the
// output register and sets min_weight to zero.
`default_nettype none

module skin_weight_top4_normalize (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // Influence stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata from bit 0: bone_id[7:0], weight[27:8], bind_x[51:28], bind_y[75:52], zero pad.
    input  wire logic [swn_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                               s_tlast,

    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata from bit 0: out_bone_id[7:0], norm_weight[24:8], out_bind_x[48:25],
    // out_bind_y[72:49], zero pad.
    output logic [swn_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                    m_tlast,
    // m_tuser from bit 0: empty_set, overflowed.
    output logic [swn_pkg::OUT_USER_W-1:0]          m_tuser,

    // Register port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swn_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [swn_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [swn_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    // The drop threshold, which is also the threshold for the sum of the kept weights.
    logic [swn_pkg::WEIGHT_W-1:0] r_min_weight;

    logic              push;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    swn_pkg::t_q_entry push_entry;
    swn_pkg::t_q_entry head_entry;

    // The register port never waits. A write lands in the access phase; a write to
    // an address beyond the register list is ignored and reads back as zero.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_weight <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == swn_pkg::REG_MIN_WEIGHT)) begin
            r_min_weight <= pwdata[swn_pkg::WEIGHT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == swn_pkg::REG_MIN_WEIGHT) begin
            prdata = {{swn_pkg::CFG_PAD_W{1'b0}}, r_min_weight};
        end
    end

    // The front buffers a vertex, ranks the survivors, sums the kept weights and
    // hands the kept set to the queue in output order, one entry a cycle while the queue has room.
    swn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_weight (r_min_weight),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_bone_id    (s_tdata[7:0]),
        .i_weight     (s_tdata[27:8]),
        .i_bind_x     (s_tdata[51:28]),
        .i_bind_y     (s_tdata[75:52]),
        .i_last       (s_tlast),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_q_full     (q_full)
    );

    // The queue lets the front go on to the next vertex while the back is still
    // dividing, and lets the back drain while the front is busy ranking.
    swn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty)
    );

    // The back divides each kept weight by the kept sum and holds the result in an
    // output register, so a stalled result stream does not stop the divider at once.
    swn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_entry),
        .o_pop     (pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_data    (m_tdata),
        .o_last    (m_tlast),
        .o_user    (m_tuser)
    );

endmodule

`default_nettype wire

[sv/swn_front.sv]
// Front part of the normaliser: buffers the influences of one vertex, ranks them,
// sums the kept weights and pushes the kept set into the queue in output order.
// Depends on swn_pkg.
`default_nettype none

module swn_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [swn_pkg::WEIGHT_W-1:0]        i_min_weight,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [swn_pkg::ID_W-1:0]            i_bone_id,
    input  wire logic [swn_pkg::WEIGHT_W-1:0]        i_weight,
    input  wire logic signed [swn_pkg::BIND_W-1:0]   i_bind_x,
    input  wire logic signed [swn_pkg::BIND_W-1:0]   i_bind_y,
    input  wire logic                                i_last,
    output logic                                     o_push,
    output swn_pkg::t_q_entry                        o_entry,
    input  wire logic                                i_q_full
);

    logic        [swn_pkg::ID_W-1:0]     r_ids     [swn_pkg::MAX_INFLUENCES];
    logic        [swn_pkg::WEIGHT_W-1:0] r_weights [swn_pkg::MAX_INFLUENCES];
    logic signed [swn_pkg::BIND_W-1:0]   r_bind_x  [swn_pkg::MAX_INFLUENCES];
    logic signed [swn_pkg::BIND_W-1:0]   r_bind_y  [swn_pkg::MAX_INFLUENCES];
    logic        [swn_pkg::CNT_W-1:0]    r_pos     [swn_pkg::MAX_INFLUENCES];

    swn_pkg::t_front_state r_state, n_state;
    logic [swn_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic [swn_pkg::IDX_W-1:0] r_j, n_j;
    logic [swn_pkg::CNT_W-1:0] r_p, n_p;
    logic [swn_pkg::SUM_W-1:0] r_sum, n_sum;

    logic [swn_pkg::MAX_INFLUENCES-1:0] v_mask;
    logic [swn_pkg::CNT_W-1:0]          n_valid;
    logic                               big;
    logic [swn_pkg::CNT_W-1:0]          keep;
    logic [swn_pkg::IDX_W-1:0]          sel_idx;
    logic [swn_pkg::IDX_W-1:0]          rd_idx;
    logic [swn_pkg::WEIGHT_W-1:0]       rd_w;
    logic                               in_acc;
    logic                               set_empty;
    logic                               is_last;
    logic [swn_pkg::MAX_INFLUENCES-1:0] beat;

    assign o_ready = (r_state == swn_pkg::F_LOAD);
    assign in_acc  = i_valid && o_ready;

    // An entry survives when it was loaded and its weight is above the threshold.
    always_comb begin
        n_valid = '0;
        for (int i = 0; i < swn_pkg::MAX_INFLUENCES; i++) begin
            v_mask[i] = (swn_pkg::CNT_W'(i) < r_count) && (r_weights[i] > i_min_weight);
            n_valid   = n_valid + swn_pkg::CNT_W'(v_mask[i]);
        end
    end

    assign big  = n_valid > swn_pkg::CNT_W'(swn_pkg::KEEP_COUNT);
    assign keep = big ? swn_pkg::CNT_W'(swn_pkg::KEEP_COUNT) : n_valid;

    // The surviving entry whose output position matches the current one.
    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < swn_pkg::MAX_INFLUENCES; i++) begin
            if (v_mask[i] && (r_pos[i] == r_p)) begin
                sel_idx = swn_pkg::IDX_W'(i);
            end
        end
    end

    assign rd_idx = (r_state == swn_pkg::F_RANK) ? r_j : sel_idx;
    assign rd_w   = r_weights[rd_idx];

    // Entry r_j goes ahead of entry i: by weight with ties in arrival order when
    // the set is cut down, by arrival order alone otherwise.
    always_comb begin
        for (int i = 0; i < swn_pkg::MAX_INFLUENCES; i++) begin
            if (big) begin
                beat[i] = (rd_w > r_weights[i]) ||
                          ((rd_w == r_weights[i]) && (r_j < swn_pkg::IDX_W'(i)));
            end else begin
                beat[i] = r_j < swn_pkg::IDX_W'(i);
            end
        end
    end

    assign set_empty = (keep == '0) || (r_sum <= swn_pkg::SUM_W'(i_min_weight));
    assign is_last   = swn_pkg::CNT_W'(r_p + 1'b1) == keep;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_j     = r_j;
        n_p     = r_p;
        n_sum   = r_sum;
        o_push  = 1'b0;

        o_entry        = '0;
        o_entry.sum    = r_sum;
        o_entry.ovf    = r_ovf;
        if (set_empty) begin
            o_entry.empty = 1'b1;
            o_entry.last  = 1'b1;
        end else begin
            o_entry.id     = r_ids[rd_idx];
            o_entry.weight = rd_w;
            o_entry.bind_x = r_bind_x[rd_idx];
            o_entry.bind_y = r_bind_y[rd_idx];
            o_entry.last   = is_last;
        end

        unique case (r_state)
            swn_pkg::F_LOAD: begin
                if (in_acc) begin
                    if (r_count < swn_pkg::CNT_W'(swn_pkg::MAX_INFLUENCES)) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = swn_pkg::F_RANK;
                        n_j     = '0;
                    end
                end
            end
            swn_pkg::F_RANK: begin
                n_j = r_j + 1'b1;
                if (r_j == swn_pkg::IDX_W'(swn_pkg::MAX_INFLUENCES - 1)) begin
                    n_state = swn_pkg::F_SUM;
                    n_p     = '0;
                    n_sum   = '0;
                end
            end
            swn_pkg::F_SUM: begin
                if (r_p == keep) begin
                    n_state = swn_pkg::F_PUSH;
                    n_p     = '0;
                end else begin
                    n_sum = r_sum + swn_pkg::SUM_W'(rd_w);
                    n_p   = r_p + 1'b1;
                end
            end
            swn_pkg::F_PUSH: begin
                o_push = !i_q_full;
                if (!i_q_full) begin
                    if (set_empty || is_last) begin
                        n_state = swn_pkg::F_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end
            end
            default: begin
                n_state = swn_pkg::F_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swn_pkg::F_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_j     <= '0;
            r_p     <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_j     <= n_j;
            r_p     <= n_p;
            r_sum   <= n_sum;
        end
    end

    // Influence buffer and per-entry output positions.
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < swn_pkg::CNT_W'(swn_pkg::MAX_INFLUENCES))) begin
            r_ids[r_count[swn_pkg::IDX_W-1:0]]     <= i_bone_id;
            r_weights[r_count[swn_pkg::IDX_W-1:0]] <= i_weight;
            r_bind_x[r_count[swn_pkg::IDX_W-1:0]]  <= i_bind_x;
            r_bind_y[r_count[swn_pkg::IDX_W-1:0]]  <= i_bind_y;
        end
        for (int i = 0; i < swn_pkg::MAX_INFLUENCES; i++) begin
            if (in_acc && i_last) begin
                r_pos[i] <= '0;
            end else if ((r_state == swn_pkg::F_RANK) && v_mask[r_j] && beat[i]) begin
                r_pos[i] <= r_pos[i] + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/swn_queue.sv]
// Short first-in first-out queue of kept influences between the front and the back.
// Depends on swn_pkg for the entry type and depth.
`default_nettype none

module swn_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire swn_pkg::t_q_entry i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output swn_pkg::t_q_entry      o_head,
    output logic                   o_empty
);

    swn_pkg::t_q_entry r_mem [swn_pkg::Q_DEPTH];

    logic [swn_pkg::Q_PTR_W-1:0] r_wr, n_wr;
    logic [swn_pkg::Q_PTR_W-1:0] r_rd, n_rd;
    logic [swn_pkg::Q_PTR_W:0]   r_cnt, n_cnt;

    assign o_full  = r_cnt == (swn_pkg::Q_PTR_W + 1)'(swn_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push && !o_full) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd = r_rd + 1'b1;
        end
        if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[sv/swn_back.sv]
// Back part of the normaliser: takes kept influences from the queue, divides each
// weight by the kept sum one quotient bit per cycle and holds the result for transfer.
// Depends on swn_pkg.
`default_nettype none

module swn_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_empty,
    input  wire swn_pkg::t_q_entry                   i_head,
    output logic                                     o_pop,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [swn_pkg::OUT_DATA_W-1:0]           o_data,
    output logic                                     o_last,
    output logic [swn_pkg::OUT_USER_W-1:0]           o_user
);

    swn_pkg::t_back_state r_state, n_state;
    swn_pkg::t_q_entry    r_ent, n_ent;

    logic [swn_pkg::SUM_W-1:0]     r_rem, n_rem;
    logic [swn_pkg::NORM_W-1:0]    r_dlow, n_dlow;
    logic [swn_pkg::NORM_W-1:0]    r_quo, n_quo;
    logic [swn_pkg::DIV_CNT_W-1:0] r_step, n_step;

    logic                           r_out_valid, n_out_valid;
    logic [swn_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                           r_out_last, n_out_last;
    logic [swn_pkg::OUT_USER_W-1:0] r_out_user, n_out_user;

    logic [swn_pkg::SUM_W:0] trial;
    logic                    q_bit;
    logic [swn_pkg::SUM_W:0] diff;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;
    assign o_user  = r_out_user;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    assign trial = {r_rem, r_dlow[swn_pkg::NORM_W-1]};
    assign diff  = trial - {1'b0, r_ent.sum};
    assign q_bit = trial >= {1'b0, r_ent.sum};

    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_rem       = r_rem;
        n_dlow      = r_dlow;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        o_pop       = 1'b0;

        unique case (r_state)
            swn_pkg::B_IDLE: begin
                o_pop = !i_q_empty;
                if (!i_q_empty) begin
                    n_ent  = i_head;
                    n_quo  = '0;
                    n_step = '0;
                    // The quotient fits 17 bits, so the top of the dividend
                    // starts below the divisor.
                    n_rem  = swn_pkg::SUM_W'(i_head.weight >> 1);
                    n_dlow = {i_head.weight[0], {swn_pkg::FRAC_W{1'b0}}};
                    n_state = i_head.empty ? swn_pkg::B_HOLD : swn_pkg::B_DIV;
                end
            end
            swn_pkg::B_DIV: begin
                n_rem  = q_bit ? diff[swn_pkg::SUM_W-1:0] : trial[swn_pkg::SUM_W-1:0];
                n_quo  = {r_quo[swn_pkg::NORM_W-2:0], q_bit};
                n_dlow = {r_dlow[swn_pkg::NORM_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == swn_pkg::DIV_CNT_W'(swn_pkg::NORM_W - 1)) begin
                    n_state = swn_pkg::B_HOLD;
                end
            end
            swn_pkg::B_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{swn_pkg::OUT_PAD_W{1'b0}}, r_ent.bind_y, r_ent.bind_x,
                                   r_quo, r_ent.id};
                    n_out_last  = r_ent.last;
                    n_out_user  = {r_ent.ovf, r_ent.empty};
                    n_state     = swn_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = swn_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swn_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_rem      <= n_rem;
        r_dlow     <= n_dlow;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

endmodule

`default_nettype wire

[dv/tb_skin_weight_top4_normalize.sv]
// Self-checking testbench for skin_weight_top4_normalize: drives influence transfers and
// register writes, predicts every normalised result and compares it field by field.
// Depends on swn_pkg (sv/swn_pkg.sv) and the skin_weight_top4_normalize RTL.
`default_nettype none

module tb_skin_weight_top4_normalize;

    // Result of one kept influence, or the single empty marker of a vertex.
    typedef struct packed {
        logic [swn_pkg::ID_W-1:0]          bone_id;
        logic [swn_pkg::NORM_W-1:0]        norm_weight;
        logic signed [swn_pkg::BIND_W-1:0] bind_x;
        logic signed [swn_pkg::BIND_W-1:0] bind_y;
        logic                              empty_set;
        logic                              overflowed;
        logic                              last_out;
    } t_norm_result;

    typedef enum logic {
        ROW_INFLUENCE,
        ROW_MIN_WEIGHT
    } t_row_kind;

    // One row of the directed table. A typed row carries its expected result; every other
    // influence row is checked against the predictor.
    typedef struct {
        t_row_kind                    kind;
        logic [swn_pkg::ID_W-1:0]     bone_id;
        logic [swn_pkg::WEIGHT_W-1:0] weight;
        logic [swn_pkg::BIND_W-1:0]   bind_x;
        logic [swn_pkg::BIND_W-1:0]   bind_y;
        logic                         last_in;
        bit                           typed;
        t_norm_result                 want;
    } t_stim_row;

    localparam logic [swn_pkg::WEIGHT_W-1:0] WEIGHT_MAX   = {swn_pkg::WEIGHT_W{1'b1}};
    localparam logic [swn_pkg::WEIGHT_W-1:0] WEIGHT_ONE   = 20'h10000;
    localparam logic [swn_pkg::NORM_W-1:0]   NORM_ONE     = 17'h10000;
    localparam int                           DRAIN_CYCLES = 60;
    localparam int                           HOLD_CYCLES  = 400;
    localparam int                           IDLE_PCT     = 13;
    localparam int                           RANDOM_ITEMS = 255;

    // Clock, reset and all block inputs start at known values.
    logic                             i_clk   = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [swn_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [swn_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic [swn_pkg::OUT_USER_W-1:0]   m_tuser;
    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [swn_pkg::CFG_ADDR_W-1:0]   paddr   = '0;
    logic [swn_pkg::CFG_DATA_W-1:0]   pwdata  = '0;
    logic [swn_pkg::CFG_DATA_W-1:0]   prdata;
    logic                             pready;

    skin_weight_top4_normalize dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the block's buffer and threshold, kept by the predictor.
    logic [swn_pkg::ID_W-1:0]     held_id [swn_pkg::MAX_INFLUENCES];
    logic [swn_pkg::WEIGHT_W-1:0] held_w  [swn_pkg::MAX_INFLUENCES];
    logic [swn_pkg::BIND_W-1:0]   held_bx [swn_pkg::MAX_INFLUENCES];
    logic [swn_pkg::BIND_W-1:0]   held_by [swn_pkg::MAX_INFLUENCES];
    int                           held_n = 0;
    bit                           lost_seen = 1'b0;
    logic [swn_pkg::WEIGHT_W-1:0] threshold = '0;

    t_norm_result        pending_results [$];
    t_stim_row           directed [$];
    int                  errors = 0;
    int                  results_seen = 0;
    int                  items_sent = 0;
    bit                  quiet = 1'b0;

    // The clock runs with a period of four time units.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A generous fixed limit: a hung handshake ends the run as a failure.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_norm_result result_of(logic [swn_pkg::ID_W-1:0] id,
                                               logic [swn_pkg::NORM_W-1:0] nw,
                                               logic [swn_pkg::BIND_W-1:0] bx,
                                               logic [swn_pkg::BIND_W-1:0] by,
                                               logic empty, logic ovf, logic last);
        t_norm_result r;
        r.bone_id     = id;
        r.norm_weight = nw;
        r.bind_x      = bx;
        r.bind_y      = by;
        r.empty_set   = empty;
        r.overflowed  = ovf;
        r.last_out    = last;
        return r;
    endfunction

    function automatic t_stim_row influence_row(logic [swn_pkg::ID_W-1:0] id,
                                                logic [swn_pkg::WEIGHT_W-1:0] w,
                                                logic [swn_pkg::BIND_W-1:0] bx,
                                                logic [swn_pkg::BIND_W-1:0] by,
                                                logic last);
        t_stim_row r;
        r.kind    = ROW_INFLUENCE;
        r.bone_id = id;
        r.weight  = w;
        r.bind_x  = bx;
        r.bind_y  = by;
        r.last_in = last;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_stim_row typed_row(logic [swn_pkg::ID_W-1:0] id,
                                            logic [swn_pkg::WEIGHT_W-1:0] w,
                                            logic [swn_pkg::BIND_W-1:0] bx,
                                            logic [swn_pkg::BIND_W-1:0] by,
                                            t_norm_result want);
        t_stim_row r;
        r       = influence_row(id, w, bx, by, 1'b1);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row threshold_row(logic [swn_pkg::WEIGHT_W-1:0] value);
        t_stim_row r;
        r        = influence_row('0, value, '0, '0, 1'b0);
        r.kind   = ROW_MIN_WEIGHT;
        return r;
    endfunction

    // Buffers one accepted influence and, on the final one of a vertex, works out the
    // normalised set: filter by threshold, stable descending sort when more than four
    // survive, keep the top four, then divide each weight by the kept sum.
    task automatic predict_influence(input logic [swn_pkg::ID_W-1:0] id,
                                     input logic [swn_pkg::WEIGHT_W-1:0] w,
                                     input logic [swn_pkg::BIND_W-1:0] bx,
                                     input logic [swn_pkg::BIND_W-1:0] by,
                                     input logic last, input bit typed,
                                     input t_norm_result want);
        int           sel [swn_pkg::MAX_INFLUENCES];
        int           n;
        int           keep;
        int           i;
        int           j;
        int           v;
        logic [63:0]  sum;
        logic [63:0]  quot;
        t_norm_result r;
        if (held_n < swn_pkg::MAX_INFLUENCES) begin
            held_id[held_n] = id;
            held_w[held_n]  = w;
            held_bx[held_n] = bx;
            held_by[held_n] = by;
            held_n++;
        end else begin
            lost_seen = 1'b1;
        end
        if (!last) return;

        n = 0;
        for (i = 0; i < held_n; i++) begin
            if (held_w[i] > threshold) begin
                sel[n] = i;
                n++;
            end
        end
        keep = n;
        if (n > swn_pkg::KEEP_COUNT) begin
            // Insertion sort moves an entry only past strictly lighter ones, so ties keep
            // their arrival order.
            for (i = 1; i < n; i++) begin
                v = sel[i];
                j = i;
                while (j > 0 && held_w[sel[j-1]] < held_w[v]) begin
                    sel[j] = sel[j-1];
                    j--;
                end
                sel[j] = v;
            end
            keep = swn_pkg::KEEP_COUNT;
        end
        sum = '0;
        for (i = 0; i < keep; i++) sum += 64'(held_w[sel[i]]);

        if (typed) begin
            pending_results.insert(pending_results.size(), want);
        end else if (keep == 0 || sum <= 64'(threshold)) begin
            pending_results.insert(pending_results.size(),
                                   result_of('0, '0, '0, '0, 1'b1, lost_seen, 1'b1));
        end else begin
            for (i = 0; i < keep; i++) begin
                quot = (64'(held_w[sel[i]]) << swn_pkg::FRAC_W) / sum;
                r = result_of(held_id[sel[i]], quot[swn_pkg::NORM_W-1:0], held_bx[sel[i]],
                              held_by[sel[i]], 1'b0, lost_seen, 1'b1 ? (i + 1 == keep) : 1'b0);
                pending_results.insert(pending_results.size(), r);
            end
        end
        held_n    = 0;
        lost_seen = 1'b0;
    endtask

    // Offers one influence, idling beforehand now and then, and waits for the transfer.
    task automatic send_influence(input logic [swn_pkg::ID_W-1:0] id,
                                  input logic [swn_pkg::WEIGHT_W-1:0] w,
                                  input logic [swn_pkg::BIND_W-1:0] bx,
                                  input logic [swn_pkg::BIND_W-1:0] by,
                                  input logic last, input bit typed, input t_norm_result want);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(swn_pkg::IN_DATA_W - swn_pkg::ID_W - swn_pkg::WEIGHT_W -
                       2 * swn_pkg::BIND_W){1'b0}}, by, bx, w, id};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        predict_influence(id, w, bx, by, last, typed, want);
    endtask

    // Lets the block drain, then writes min_weight over the register port and reads it
    // back. The read setup follows the write access directly so that psel stays high.
    task automatic write_threshold(input logic [swn_pkg::WEIGHT_W-1:0] value);
        logic [swn_pkg::CFG_DATA_W-1:0] word;
        word = {{swn_pkg::CFG_PAD_W{1'b0}}, value};
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {swn_pkg::REG_MIN_WEIGHT, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        threshold = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== word) begin
            $error("min_weight readback: expected %0h, actual %0h", word, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [swn_pkg::WEIGHT_W-1:0] pick_weight(int mode);
        int t;
        case (mode)
            0: return swn_pkg::WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
            1: begin
                // A small set of values, so that ties are frequent.
                case ($urandom_range(2))
                    0: return 20'h04000;
                    1: return 20'h08000;
                    default: return 20'h0C000;
                endcase
            end
            2: begin
                // Just below, at or just above the threshold.
                t = int'(threshold) + int'($urandom_range(0, 2)) - 1;
                if (t < 0) t = 0;
                if (t > int'(WEIGHT_MAX)) t = int'(WEIGHT_MAX);
                return swn_pkg::WEIGHT_W'(t);
            end
            default: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return WEIGHT_MAX;
                    2: return swn_pkg::WEIGHT_W'($urandom_range(0, 255));
                    default: return swn_pkg::WEIGHT_W'($urandom());
                endcase
            end
        endcase
    endfunction

    // One vertex of random influences: mostly four or fewer, some needing the top-four
    // selection, and now and then more than the buffer holds.
    task automatic send_random_vertex();
        int count;
        int mode;
        int i;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            count = $urandom_range(swn_pkg::MAX_INFLUENCES + 1, swn_pkg::MAX_INFLUENCES + 3);
        end else if (pick < 30) begin
            count = $urandom_range(swn_pkg::KEEP_COUNT + 1, swn_pkg::MAX_INFLUENCES);
        end else begin
            count = $urandom_range(1, swn_pkg::KEEP_COUNT);
        end
        mode = $urandom_range(3);
        for (i = 0; i < count; i++) begin
            send_influence(swn_pkg::ID_W'($urandom()), pick_weight(mode),
                           swn_pkg::BIND_W'($urandom()), swn_pkg::BIND_W'($urandom()),
                           i == count - 1, 1'b0, '0);
        end
    endtask

    // Compares one field of a result transfer with its expected value.
    function automatic void check_field(string name, logic [swn_pkg::BIND_W-1:0] want,
                                        logic [swn_pkg::BIND_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_result();
        t_norm_result got;
        t_norm_result want;
        got = result_of(m_tdata[7:0], m_tdata[24:8], m_tdata[48:25], m_tdata[72:49],
                        m_tuser[0], m_tuser[1], m_tlast);
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("result with no expectation waiting: bone %0h weight %0h",
                   got.bone_id, got.norm_weight);
            errors++;
        end else begin
            want = pending_results.pop_front();
            check_field("out_bone_id", swn_pkg::BIND_W'(want.bone_id),
                        swn_pkg::BIND_W'(got.bone_id));
            check_field("norm_weight", swn_pkg::BIND_W'(want.norm_weight),
                        swn_pkg::BIND_W'(got.norm_weight));
            check_field("out_bind_x", want.bind_x, got.bind_x);
            check_field("out_bind_y", want.bind_y, got.bind_y);
            check_field("empty_set", swn_pkg::BIND_W'(want.empty_set),
                        swn_pkg::BIND_W'(got.empty_set));
            check_field("overflowed", swn_pkg::BIND_W'(want.overflowed),
                        swn_pkg::BIND_W'(got.overflowed));
            check_field("last_out", swn_pkg::BIND_W'(want.last_out),
                        swn_pkg::BIND_W'(got.last_out));
            check_field("m_tdata pad", '0,
                        swn_pkg::BIND_W'(m_tdata[swn_pkg::OUT_DATA_W-1:73]));
        end
    endtask

    // Result side. Values are read at the rising edge before the block updates them, so
    // a transfer is seen exactly where tvalid and tready were both high. Once some results
    // have passed, tready is held low for a long stretch so that the queue fills and the
    // block stalls its influence input while the sender keeps offering.
    initial begin : result_sink
        int  hold;
        bit  hold_done;
        hold      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) check_result();
            if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus: reset, the directed table, then random vertices with threshold changes.
    initial begin : stimulus
        int        r;
        int        start_items;
        t_stim_row row;

        // Directed table. The first rows are simple enough to type their result in: a
        // single unit weight and a single maximum weight each normalise to exactly one, and
        // a lone zero weight leaves nothing above the reset threshold.
        directed.insert(directed.size(), typed_row(8'h00, WEIGHT_ONE, 24'h800000, 24'h7FFFFF,
                        result_of(8'h00, NORM_ONE, 24'h800000, 24'h7FFFFF, 0, 0, 1)));
        directed.insert(directed.size(), typed_row(8'hFF, WEIGHT_MAX, 24'h7FFFFF, 24'h800000,
                        result_of(8'hFF, NORM_ONE, 24'h7FFFFF, 24'h800000, 0, 0, 1)));
        directed.insert(directed.size(), typed_row(8'h5A, 20'h00000, 24'h123456, 24'hFEDCBA,
                        result_of('0, '0, '0, '0, 1, 0, 1)));
        // Two equal weights, kept in arrival order.
        directed.insert(directed.size(),
                        influence_row(8'h01, 20'h08000, 24'h000100, 24'hFFFF00, 0));
        directed.insert(directed.size(),
                        influence_row(8'h02, 20'h08000, 24'h000200, 24'hFFFE00, 1));
        // Six influences: top four chosen by weight, with ties resolved by arrival.
        directed.insert(directed.size(),
                        influence_row(8'h10, 20'h03000, 24'h000010, 24'h000011, 0));
        directed.insert(directed.size(),
                        influence_row(8'h11, 20'h05000, 24'h000020, 24'h000021, 0));
        directed.insert(directed.size(),
                        influence_row(8'h12, 20'h03000, 24'h000030, 24'h000031, 0));
        directed.insert(directed.size(),
                        influence_row(8'h13, 20'h07000, 24'h000040, 24'h000041, 0));
        directed.insert(directed.size(),
                        influence_row(8'h14, 20'h03000, 24'h000050, 24'h000051, 0));
        directed.insert(directed.size(),
                        influence_row(8'h15, 20'h01000, 24'h000060, 24'h000061, 1));
        // Nine influences: the ninth, the final one, is lost to the full buffer.
        for (r = 0; r < swn_pkg::MAX_INFLUENCES; r++) begin
            directed.insert(directed.size(),
                            influence_row(8'h20 + swn_pkg::ID_W'(r),
                                          20'h01000 * swn_pkg::WEIGHT_W'(r + 1),
                                          swn_pkg::BIND_W'(r), ~swn_pkg::BIND_W'(r), 0));
        end
        directed.insert(directed.size(),
                        influence_row(8'h2F, WEIGHT_MAX, 24'h0000AA, 24'h0000BB, 1));
        // Highest threshold: not even the largest weight survives.
        directed.insert(directed.size(), threshold_row(WEIGHT_MAX));
        directed.insert(directed.size(), typed_row(8'h33, WEIGHT_MAX, 24'h000001, 24'h000002,
                        result_of('0, '0, '0, '0, 1, 0, 1)));
        // A mid threshold drops the lighter of two.
        directed.insert(directed.size(), threshold_row(20'h20000));
        directed.insert(directed.size(),
                        influence_row(8'h40, 20'h30000, 24'hABCDEF, 24'h012345, 0));
        directed.insert(directed.size(),
                        influence_row(8'h41, 20'h10000, 24'h543210, 24'hFEDCBA, 1));
        // The threshold changes while a vertex is half loaded and applies to it.
        directed.insert(directed.size(), threshold_row('0));
        directed.insert(directed.size(),
                        influence_row(8'h50, 20'h08000, 24'h111111, 24'h222222, 0));
        directed.insert(directed.size(), threshold_row(20'h08000));
        directed.insert(directed.size(),
                        influence_row(8'h51, 20'h09000, 24'h333333, 24'h444444, 1));

        // Reset is applied once, at the start.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        held_n    = 0;
        lost_seen = 1'b0;
        threshold = '0;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            if (row.kind == ROW_MIN_WEIGHT) begin
                write_threshold(row.weight);
            end else begin
                send_influence(row.bone_id, row.weight, row.bind_x, row.bind_y, row.last_in,
                               row.typed, row.want);
            end
        end

        // Random vertices. A stretch in the middle runs with neither side idling.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            quiet = (items_sent - start_items >= 100) && (items_sent - start_items < 180);
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(5))
                    0, 1:    write_threshold('0);
                    2:       write_threshold(swn_pkg::WEIGHT_W'($urandom_range(0, 20'h03FFF)));
                    3:       write_threshold(swn_pkg::WEIGHT_W'($urandom()));
                    4:       write_threshold(WEIGHT_MAX);
                    default: write_threshold(WEIGHT_ONE);
                endcase
            end
            send_random_vertex();
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Every expectation must be met; the limit above catches any that never is.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
